FILE: src/comment_stripper_line_column_defines.svh
`ifndef COMMENT_STRIPPER_LINE_COLUMN_DEFINES_SVH
`define COMMENT_STRIPPER_LINE_COLUMN_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CSLC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CSLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/cslc_pkg.sv
`timescale 1ns / 1ps
package cslc_pkg;

  localparam int CHAR_W    = 21;
  localparam int POS_OUT_W = 16;

  localparam logic [CHAR_W-1:0] CH_SLASH   = 21'h00002F;
  localparam logic [CHAR_W-1:0] CH_STAR    = 21'h00002A;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 21'h00000A;
  localparam logic [CHAR_W-1:0] CH_END     = 21'h000000;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_SLASH      = 3'd1,
    MODE_BLOCK      = 3'd2,
    MODE_BLOCK_STAR = 3'd3,
    MODE_LINE       = 3'd4
  } lex_mode_e;

  // one queue entry: an optional held slash, then the main result
  typedef struct packed {
    logic                 has_slash;
    logic [POS_OUT_W-1:0] slash_line;
    logic [POS_OUT_W-1:0] slash_column;
    logic [CHAR_W-1:0]    ch;
    logic [POS_OUT_W-1:0] line;
    logic [POS_OUT_W-1:0] column;
    logic                 eot;
    logic                 unterm;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage

FILE: src/cslc_if.sv
`timescale 1ns / 1ps
interface cslc_in_if;
  import cslc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface cslc_out_if;
  import cslc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CHAR_W-1:0]    out_char;
  logic [POS_OUT_W-1:0] out_line;
  logic [POS_OUT_W-1:0] out_column;
  logic                 end_of_text;
  logic                 unterminated;
  logic                 run_last;

  modport source (
    output valid, output out_char, output out_line, output out_column,
    output end_of_text, output unterminated, output run_last, input ready
  );
  modport sink (
    input valid, input out_char, input out_line, input out_column,
    input end_of_text, input unterminated, input run_last, output ready
  );
endinterface

FILE: src/cslc_front.sv
`timescale 1ns / 1ps
module cslc_front #(
  parameter int POSITION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cslc_in_if.sink               in_i,
  input  cslc_pkg::queue_stat_t stat_i,
  output logic                  push_o,
  output cslc_pkg::entry_t      entry_o
);
  import cslc_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  lex_mode_e                mode_q, mode_d;
  logic [POSITION_BITS-1:0] line_q, line_d;
  logic [POSITION_BITS-1:0] col_q, col_d;
  logic [POSITION_BITS-1:0] cs_line_q, cs_line_d;
  logic [POSITION_BITS-1:0] cs_col_q, cs_col_d;

  logic                     accept;
  logic                     is_nl;
  logic [POSITION_BITS-1:0] col_inc, line_inc, col_adv, line_adv;
  logic [CHAR_W-1:0]        ch;

  assign in_i.ready = !stat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign ch         = in_i.char_code;

  // saturating position advance for one consumed character
  assign is_nl    = (ch == CH_NEWLINE);
  assign col_inc  = (col_q != POS_MAX) ? col_q + POS_ONE : col_q;
  assign line_inc = (line_q != POS_MAX) ? line_q + POS_ONE : line_q;
  assign col_adv  = is_nl ? '0 : col_inc;
  assign line_adv = is_nl ? line_inc : line_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NORMAL;
      line_q    <= POS_ONE;
      col_q     <= '0;
      cs_line_q <= '0;
      cs_col_q  <= '0;
    end else begin
      mode_q    <= mode_d;
      line_q    <= line_d;
      col_q     <= col_d;
      cs_line_q <= cs_line_d;
      cs_col_q  <= cs_col_d;
    end
  end

  always_comb begin
    mode_d    = mode_q;
    line_d    = line_q;
    col_d     = col_q;
    cs_line_d = cs_line_q;
    cs_col_d  = cs_col_q;
    push_o    = 1'b0;

    entry_o.has_slash    = 1'b0;
    entry_o.slash_line   = POS_OUT_W'(cs_line_q);
    entry_o.slash_column = POS_OUT_W'(cs_col_q);
    entry_o.ch           = ch;
    entry_o.line         = POS_OUT_W'(line_adv);
    entry_o.column       = POS_OUT_W'(col_adv);
    entry_o.eot          = 1'b0;
    entry_o.unterm       = 1'b0;

    if (accept) begin
      if (ch == CH_END) begin
        push_o            = 1'b1;
        entry_o.has_slash = (mode_q == MODE_SLASH);
        entry_o.ch        = CH_END;
        entry_o.eot       = 1'b1;
        if (mode_q == MODE_BLOCK || mode_q == MODE_BLOCK_STAR) begin
          entry_o.unterm = 1'b1;
          entry_o.line   = POS_OUT_W'(cs_line_q);
          entry_o.column = POS_OUT_W'(cs_col_q);
        end else begin
          entry_o.line   = POS_OUT_W'(line_q);
          entry_o.column = POS_OUT_W'(col_q);
        end
        // back to the reset state for the next text
        mode_d    = MODE_NORMAL;
        line_d    = POS_ONE;
        col_d     = '0;
        cs_line_d = '0;
        cs_col_d  = '0;
      end else begin
        line_d = line_adv;
        col_d  = col_adv;
        unique case (mode_q)
          MODE_SLASH: begin
            if (ch == CH_STAR) begin
              mode_d = MODE_BLOCK;
            end else if (ch == CH_SLASH) begin
              mode_d = MODE_LINE;
            end else begin
              push_o            = 1'b1;
              entry_o.has_slash = 1'b1;
              mode_d            = MODE_NORMAL;
            end
          end
          MODE_BLOCK: begin
            if (ch == CH_STAR) begin
              mode_d = MODE_BLOCK_STAR;
            end
          end
          MODE_BLOCK_STAR: begin
            if (ch == CH_SLASH) begin
              mode_d = MODE_NORMAL;
            end else if (ch != CH_STAR) begin
              mode_d = MODE_BLOCK;
            end
          end
          MODE_LINE: begin
            if (is_nl) begin
              push_o = 1'b1;
              mode_d = MODE_NORMAL;
            end
          end
          default: begin
            if (ch == CH_SLASH) begin
              // position recorded after the slash is counted
              cs_line_d = line_adv;
              cs_col_d  = col_adv;
              mode_d    = MODE_SLASH;
            end else begin
              push_o = 1'b1;
              mode_d = MODE_NORMAL;
            end
          end
        endcase
      end
    end
  end

endmodule

FILE: src/cslc_fifo.sv
`timescale 1ns / 1ps
module cslc_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  cslc_pkg::entry_t      entry_i,
  input  logic                  pop_i,
  output cslc_pkg::entry_t      head_o,
  output cslc_pkg::queue_stat_t stat_o
);
  import cslc_pkg::*;

  localparam logic [QUEUE_IDX_W:0]   COUNT_FULL = (QUEUE_IDX_W + 1)'(QUEUE_DEPTH);
  localparam logic [QUEUE_IDX_W-1:0] IDX_LAST   = QUEUE_IDX_W'(QUEUE_DEPTH - 1);

  entry_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_IDX_W:0]   count_q;
  logic                   do_push, do_pop;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == COUNT_FULL);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == IDX_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == IDX_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: src/cslc_back.sv
`timescale 1ns / 1ps
module cslc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cslc_pkg::entry_t      head_i,
  input  cslc_pkg::queue_stat_t stat_i,
  output logic                  pop_o,
  cslc_out_if.source            out_o
);
  import cslc_pkg::*;

  logic                 out_valid_q, out_valid_d;
  logic                 slash_done_q, slash_done_d;
  logic [CHAR_W-1:0]    char_q, char_d;
  logic [POS_OUT_W-1:0] line_q, line_d;
  logic [POS_OUT_W-1:0] col_q, col_d;
  logic                 eot_q, eot_d;
  logic                 unterm_q, unterm_d;
  logic                 last_q, last_d;
  logic                 load;

  assign load = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      slash_done_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      slash_done_q <= slash_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q   <= char_d;
    line_q   <= line_d;
    col_q    <= col_d;
    eot_q    <= eot_d;
    unterm_q <= unterm_d;
    last_q   <= last_d;
  end

  always_comb begin
    out_valid_d  = out_valid_q && !out_o.ready;
    slash_done_d = slash_done_q;
    pop_o        = 1'b0;
    char_d       = char_q;
    line_d       = line_q;
    col_d        = col_q;
    eot_d        = eot_q;
    unterm_d     = unterm_q;
    last_d       = last_q;
    if (load && !stat_i.empty) begin
      out_valid_d = 1'b1;
      if (head_i.has_slash && !slash_done_q) begin
        // held slash goes out first, entry stays at the head
        char_d       = CH_SLASH;
        line_d       = head_i.slash_line;
        col_d        = head_i.slash_column;
        eot_d        = 1'b0;
        unterm_d     = 1'b0;
        last_d       = 1'b0;
        slash_done_d = 1'b1;
      end else begin
        char_d       = head_i.ch;
        line_d       = head_i.line;
        col_d        = head_i.column;
        eot_d        = head_i.eot;
        unterm_d     = head_i.unterm;
        last_d       = 1'b1;
        slash_done_d = 1'b0;
        pop_o        = 1'b1;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_char     = char_q;
  assign out_o.out_line     = line_q;
  assign out_o.out_column   = col_q;
  assign out_o.end_of_text  = eot_q;
  assign out_o.unterminated = unterm_q;
  assign out_o.run_last     = last_q;

endmodule

FILE: src/comment_stripper_line_column.sv
`timescale 1ns / 1ps
// C-style comment stripper with line and column tracking.
// in_i carries one character per transfer (char_code, zero marks end of text).
// out_o carries the surviving characters with their line and 1-based column
// (newlines at column 0), plus an end item per text; run_last marks the last
// result caused by one input character. A character may cause none, one or
// two results (a held slash followed by the character, or by the end item).
// Path: an input transfer writes its result into the four-entry queue, and
// the output register loads it from the queue head once free; the second
// result of a character leaves after the held slash, from the same entry.
// Throughput: one input character per cycle while the queue has room; with
// out_o ready, one result per cycle, so only two-result runs fill the queue.
// in_i.ready drops only when the queue between front and back is full, so with
// a stalled receiver input stops once four entries wait behind the output reg.
// Reset clears the lexer mode, sets line 1 column 0, and empties the queue and
// output register; no clearing pass is needed. After an end item the lexer
// returns to that same state, so the next text may follow at once.
// Position counters are POSITION_BITS wide and saturate; ports carry 16 bits.
module comment_stripper_line_column #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cslc_in_if.sink     in_i,
  cslc_out_if.source  out_o
);
  import cslc_pkg::*;

  `include "comment_stripper_line_column_defines.svh"

  entry_t      push_entry, head_entry;
  queue_stat_t q_stat;
  logic        push, pop;

  cslc_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .stat_i  (q_stat),
    .push_o  (push),
    .entry_o (push_entry)
  );

  cslc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .stat_o  (q_stat)
  );

  cslc_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head_entry),
    .stat_i (q_stat),
    .pop_o  (pop),
    .out_o  (out_o)
  );

  `CSLC_ASSERT_IMPLY(a_unterm_is_end, clk_i, rst_ni, out_o.valid && out_o.unterminated, out_o.end_of_text, "unterminated flag on a non-end result")
  `CSLC_ASSERT_IMPLY(a_end_closes_run, clk_i, rst_ni, out_o.valid && out_o.end_of_text, out_o.run_last, "end item does not close its run")
  `CSLC_ASSERT_IMPLY(a_lead_is_slash, clk_i, rst_ni, out_o.valid && !out_o.run_last, out_o.out_char == CH_SLASH && !out_o.end_of_text, "leading result is not a held slash")
  `CSLC_ASSERT_NEXT(a_slash_followed, clk_i, rst_ni, out_o.valid && out_o.ready && !out_o.run_last, out_o.valid && out_o.run_last, "held slash transfer without its companion result")

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import cslc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 400;
  localparam int TAIL_CYCLES = 8;
  localparam logic [CHAR_W-1:0] CH_LOWER_A = 21'h000061;

  typedef struct packed {
    logic [CHAR_W-1:0]    ch;
    logic [POS_OUT_W-1:0] line;
    logic [POS_OUT_W-1:0] column;
    logic                 eot;
    logic                 unterm;
    logic                 last;
  } strip_result_t;

  class strip_scoreboard;
    lex_mode_e            mode;
    logic [POS_OUT_W-1:0] line_cnt;
    logic [POS_OUT_W-1:0] col_cnt;
    logic [POS_OUT_W-1:0] open_line;
    logic [POS_OUT_W-1:0] open_col;
    strip_result_t        stripped_q[$];
    int                   errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      mode      = MODE_NORMAL;
      line_cnt  = 1;
      col_cnt   = 0;
      open_line = 0;
      open_col  = 0;
    endfunction

    // predict the results of one accepted character
    function void note_input(logic [CHAR_W-1:0] c);
      strip_result_t made[$];
      if (c == CH_END) begin
        if (mode == MODE_SLASH)
          made.push_back('{CH_SLASH, open_line, open_col, 1'b0, 1'b0, 1'b0});
        if (mode == MODE_BLOCK || mode == MODE_BLOCK_STAR)
          made.push_back('{CH_END, open_line, open_col, 1'b1, 1'b1, 1'b0});
        else
          made.push_back('{CH_END, line_cnt, col_cnt, 1'b1, 1'b0, 1'b0});
        restart();
      end else begin
        // counters saturate, comment characters count too
        if (col_cnt != '1) col_cnt++;
        if (c == CH_NEWLINE) begin
          if (line_cnt != '1) line_cnt++;
          col_cnt = 0;
        end
        case (mode)
          MODE_SLASH: begin
            if (c == CH_STAR) begin
              mode = MODE_BLOCK;
            end else if (c == CH_SLASH) begin
              mode = MODE_LINE;
            end else begin
              made.push_back('{CH_SLASH, open_line, open_col, 1'b0, 1'b0, 1'b0});
              made.push_back('{c, line_cnt, col_cnt, 1'b0, 1'b0, 1'b0});
              mode = MODE_NORMAL;
            end
          end
          MODE_BLOCK: begin
            if (c == CH_STAR) mode = MODE_BLOCK_STAR;
          end
          MODE_BLOCK_STAR: begin
            if (c == CH_SLASH) mode = MODE_NORMAL;
            else if (c != CH_STAR) mode = MODE_BLOCK;
          end
          MODE_LINE: begin
            if (c == CH_NEWLINE) begin
              made.push_back('{c, line_cnt, col_cnt, 1'b0, 1'b0, 1'b0});
              mode = MODE_NORMAL;
            end
          end
          default: begin
            if (c == CH_SLASH) begin
              open_line = line_cnt;
              open_col  = col_cnt;
              mode      = MODE_SLASH;
            end else begin
              made.push_back('{c, line_cnt, col_cnt, 1'b0, 1'b0, 1'b0});
              mode = MODE_NORMAL;
            end
          end
        endcase
      end
      if (made.size() > 0) made[made.size()-1].last = 1'b1;
      foreach (made[i]) stripped_q.push_back(made[i]);
    endfunction

    function void check(strip_result_t got);
      strip_result_t want;
      if (stripped_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: char %h line %0d col %0d eot %b unterm %b last %b",
                   got.ch, got.line, got.column, got.eot, got.unterm, got.last);
      end else begin
        want = stripped_q.pop_front();
        if (got.ch !== want.ch || got.line !== want.line || got.column !== want.column ||
            got.eot !== want.eot || got.unterm !== want.unterm || got.last !== want.last) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected char %h line %0d col %0d eot %b unterm %b last %b",
                     want.ch, want.line, want.column, want.eot, want.unterm, want.last);
            $display("          actual   char %h line %0d col %0d eot %b unterm %b last %b",
                     got.ch, got.line, got.column, got.eot, got.unterm, got.last);
          end
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cslc_in_if  in_if ();
  cslc_out_if out_if ();

  comment_stripper_line_column dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  strip_scoreboard   sb;
  int                src_idle = 0;
  int                sink_stall = 0;
  int                sent;
  int unsigned       cycles = 0;
  logic [CHAR_W-1:0] text_q[$];

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) cycles <= cycles + 1;

  always @(posedge clk_i or negedge rst_ni) begin : sink_side
    strip_result_t got;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.out_char, out_if.out_line, out_if.out_column,
                out_if.end_of_text, out_if.unterminated, out_if.run_last};
        sb.check(got);
      end
      out_if.ready <= ($urandom_range(0, 99) >= sink_stall);
    end
  end

  function automatic logic [CHAR_W-1:0] text_char();
    if ($urandom_range(0, 5) == 0) text_char = 21'($urandom_range(1, 21'h1FFFFF));
    else text_char = 21'($urandom_range(32'h61, 32'h7A));
  endfunction

  function automatic logic [CHAR_W-1:0] any_char();
    case ($urandom_range(0, 7))
      0: any_char = 21'($urandom);
      1: any_char = CH_SLASH;
      2: any_char = CH_STAR;
      3: any_char = CH_NEWLINE;
      default: any_char = text_char();
    endcase
  endfunction

  // mostly well-formed comment structure with random content
  task automatic build_text();
    text_q.delete();
    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(0, 7))
        0: repeat ($urandom_range(1, 5)) text_q.push_back(text_char());
        1: text_q.push_back(CH_NEWLINE);
        2: begin
          text_q.push_back(CH_SLASH);
          text_q.push_back(CH_STAR);
          repeat ($urandom_range(0, 6)) text_q.push_back(any_char());
          text_q.push_back(CH_STAR);
          text_q.push_back(CH_SLASH);
        end
        3: begin
          text_q.push_back(CH_SLASH);
          text_q.push_back(CH_SLASH);
          repeat ($urandom_range(0, 5)) text_q.push_back(any_char());
          text_q.push_back(CH_NEWLINE);
        end
        4: begin
          text_q.push_back(CH_SLASH);
          text_q.push_back($urandom_range(0, 1) ? CH_NEWLINE : text_char());
        end
        5: begin
          // star of the opener must not close the comment
          text_q.push_back(CH_SLASH);
          text_q.push_back(CH_STAR);
          text_q.push_back(CH_SLASH);
          text_q.push_back(text_char());
          text_q.push_back(CH_STAR);
          text_q.push_back(CH_SLASH);
        end
        6: repeat ($urandom_range(1, 4)) text_q.push_back(any_char());
        default: text_q.push_back(text_char());
      endcase
    end
    case ($urandom_range(0, 9))
      0: text_q.push_back(CH_SLASH);
      1: begin
        text_q.push_back(CH_SLASH);
        text_q.push_back(CH_STAR);
        repeat ($urandom_range(0, 4)) text_q.push_back(any_char());
      end
      2: begin
        text_q.push_back(CH_SLASH);
        text_q.push_back(CH_STAR);
        text_q.push_back(CH_STAR);
      end
      3: begin
        text_q.push_back(CH_SLASH);
        text_q.push_back(CH_SLASH);
        text_q.push_back(text_char());
      end
      default: ;
    endcase
    // sometimes the text runs on into the next one
    if ($urandom_range(0, 9) != 0) text_q.push_back(CH_END);
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] c);
    if ($urandom_range(0, 99) < src_idle) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= c;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_input(c);
    sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i]);
  endtask

  task automatic pause_until_drained();
    in_if.valid <= 1'b0;
    while (sb.stripped_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    in_if.valid     <= 1'b0;
    in_if.char_code <= CH_END;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // field extremes, overlap, held slash at end, end in line and block comments
    text_q = '{21'h1FFFFF, 21'h110000, 21'h000001, CH_NEWLINE,
               CH_SLASH, CH_STAR, CH_SLASH, CH_LOWER_A, CH_STAR, CH_SLASH,
               CH_LOWER_A + 21'd1, CH_END,
               CH_SLASH, CH_END,
               CH_SLASH, CH_SLASH, CH_LOWER_A + 21'd2, CH_END,
               CH_SLASH, CH_STAR, CH_STAR, CH_END,
               CH_SLASH, CH_LOWER_A + 21'd3, CH_END};
    send_text();
    pause_until_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 79; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 79; end
        default: begin src_idle = 8; sink_stall = 8; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_text();
        send_text();
      end
      pause_until_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.stripped_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/cslc_pkg.sv
src/cslc_if.sv
src/cslc_front.sv
src/cslc_fifo.sv
src/cslc_back.sv
src/comment_stripper_line_column.sv
tb/sv/testbench.sv
